// File: design/lpom_pkg.sv
`default_nettype none
package lpom_pkg;
	localparam logic [23:0] SPREAD_SAT = 24'hFFFFFF;
	localparam logic [0:0] ADDR_SAMPLE_COUNT = 1'b0;
	localparam logic [0:0] ADDR_OUTLIER_RATIO = 1'b1;
endpackage
`default_nettype wire

// File: design/latency_percentile_outlier_monitor_top.sv
// Operation: the completing sample of a window starts a bubble sort of n entries
// through one compare-swap unit on the sample memory, n*(n-1)/2 compares, each
// through ST_RD_A, ST_RD_B, ST_CMP and ST_NEXT (with ST_WR_B when they swap),
// then percentile fetch (ST_F5 to ST_FWAIT), class compares (ST_CLS) and a 40-step
// restoring divide before the result is offered.
// Flow: one window at a time; in_stall holds off samples outside ST_LOAD.
// Reset: arst_n clears the state, load count and sort and divide counters and sets
// sample_count=100, outlier_ratio=2; the sample memory and result registers are not cleared.
`default_nettype none
module latency_percentile_outlier_monitor_top import lpom_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] sample,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      p5_value,
	output logic [31:0]      p50_value,
	output logic [31:0]      p95_value,
	output logic [31:0]      p99_value,
	output logic [31:0]      max_value,
	output logic [2:0]       gap_class,
	output logic             hidden_outlier,
	output logic             outlier_flag,
	output logic [32:0]      timeout_value,
	output logic [23:0]      spread_ratio
);
	localparam int unsigned AW = $clog2(MAX_SAMPLES);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned PCT_SHIFT = 24;
	localparam logic [17:0] PCT_RECIP = 18'd167773; // ceil(2^24 / 100)

	typedef enum logic [4:0] {
		ST_LOAD, ST_RD_A, ST_RD_B, ST_CMP, ST_WR_B, ST_NEXT,
		ST_F5, ST_F50, ST_F95, ST_F99, ST_FMX, ST_FWAIT,
		ST_CLS, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;
	logic [7:0]  sample_count_q;
	logic [15:0] outlier_ratio_q;
	logic [CW-1:0] load_count_q;
	logic [AW-1:0] j_q, pass_q;
	logic [31:0] mem [MAX_SAMPLES];
	logic [31:0] rd_q, a_q;
	logic [31:0] p5_q, p50_q, p95_q, p99_q, mx_q;
	logic [2:0] cls_q;
	logic hid_q, out_q;
	logic [39:0] num_q;
	logic [32:0] rem_q;
	logic [5:0] dcnt_q;
	logic [AW-1:0] rd_addr;
	logic mem_we;
	logic [AW-1:0] wr_addr;
	logic [31:0] wr_data;
	logic [CW-1:0] n_eff;
	logic [CW-1:0] i5, i50, i95, i99;
	logic [CW-1:0] pos;
	logic [32:0] rem_sh, rem_sub;
	logic [47:0] ratio_prod;

	// floor(n*k/100) by reciprocal multiply, exact for n*k below 199728
	function automatic logic [CW-1:0] pct_index(input logic [CW-1:0] n, input logic [6:0] k);
		logic [47:0] prod;
		prod = 48'(n) * 48'(k) * 48'(PCT_RECIP);
		return CW'(prod >> PCT_SHIFT);
	endfunction

	// Effective window length, clamped to 2..MAX_SAMPLES
	always_comb begin
		if (sample_count_q < 8'd2) n_eff = CW'(2);
		else if (32'(sample_count_q) > MAX_SAMPLES) n_eff = CW'(MAX_SAMPLES);
		else n_eff = CW'(sample_count_q);
	end

	// Percentile indexes
	assign i5  = pct_index(n_eff, 7'd5);
	assign i50 = CW'(n_eff >> 1);
	assign i95 = pct_index(n_eff, 7'd95);
	assign i99 = pct_index(n_eff, 7'd99);
	assign pos = (load_count_q < n_eff) ? load_count_q : n_eff - CW'(1);

	assign pready = 1'b1;
	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	assign ratio_prod = 48'(p95_q) * 48'(outlier_ratio_q);
	assign rem_sh = {rem_q[31:0], num_q[39]};
	assign rem_sub = rem_sh - {1'b0, p50_q};

	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == ADDR_SAMPLE_COUNT) prdata = {24'd0, sample_count_q};
		else prdata = {16'd0, outlier_ratio_q};
	end

	// Memory read address
	always_comb begin
		case (state_q)
			ST_RD_A: rd_addr = j_q;
			ST_RD_B: rd_addr = j_q + AW'(1);
			ST_F5:   rd_addr = i5[AW-1:0];
			ST_F50:  rd_addr = i50[AW-1:0];
			ST_F95:  rd_addr = i95[AW-1:0];
			ST_F99:  rd_addr = i99[AW-1:0];
			default: rd_addr = AW'(n_eff - CW'(1));
		endcase
	end

	// Memory write port: load or swap; rd_q holds entry j+1 during ST_CMP
	always_comb begin
		mem_we = 1'b0;
		wr_addr = pos[AW-1:0];
		wr_data = sample;
		if (state_q == ST_LOAD) begin
			mem_we = in_valid;
		end else if (state_q == ST_CMP) begin
			mem_we = (a_q > rd_q);
			wr_addr = j_q;
			wr_data = rd_q;
		end else if (state_q == ST_WR_B) begin
			mem_we = 1'b1;
			wr_addr = j_q + AW'(1);
			wr_data = a_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= 8'd100;
			outlier_ratio_q <= 16'd2;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == ADDR_SAMPLE_COUNT) sample_count_q <= pwdata[7:0];
			else outlier_ratio_q <= pwdata[15:0];
		end
	end

	// Sequencer: load, sort with one compare-swap unit, fetch, classify, divide, offer the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			load_count_q <= '0;
			j_q <= '0;
			pass_q <= '0;
			dcnt_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: if (in_valid) begin
					if (pos + CW'(1) >= n_eff) begin
						load_count_q <= '0;
						j_q <= '0;
						pass_q <= '0;
						state_q <= ST_RD_A;
					end else begin
						load_count_q <= pos + CW'(1);
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: begin
					a_q <= rd_q;
					state_q <= ST_CMP;
				end
				ST_CMP: state_q <= (a_q > rd_q) ? ST_WR_B : ST_NEXT;
				ST_WR_B: state_q <= ST_NEXT;
				ST_NEXT: begin
					if (CW'(j_q) + CW'(2) < n_eff - CW'(pass_q)) begin
						j_q <= j_q + AW'(1);
						state_q <= ST_RD_A;
					end else if (CW'(pass_q) + CW'(2) < n_eff) begin
						pass_q <= pass_q + AW'(1);
						j_q <= '0;
						state_q <= ST_RD_A;
					end else begin
						state_q <= ST_F5;
					end
				end
				ST_F5: state_q <= ST_F50;
				ST_F50: begin
					p5_q <= rd_q;
					state_q <= ST_F95;
				end
				ST_F95: begin
					p50_q <= rd_q;
					state_q <= ST_F99;
				end
				ST_F99: begin
					p95_q <= rd_q;
					state_q <= ST_FMX;
				end
				ST_FMX: begin
					p99_q <= rd_q;
					state_q <= ST_FWAIT;
				end
				ST_FWAIT: begin
					mx_q <= rd_q;
					state_q <= ST_CLS;
				end
				ST_CLS: begin
					if (p50_q == 32'd0) cls_q <= 3'd4;
					else if (40'(p95_q) * 40'd100 < 40'(p50_q) * 40'd101) cls_q <= 3'd0;
					else if (40'(p95_q) * 40'd100 < 40'(p50_q) * 40'd130) cls_q <= 3'd1;
					else if (34'(p95_q) < 34'(p50_q) * 34'd3) cls_q <= 3'd2;
					else if (35'(p95_q) < 35'(p50_q) * 35'd5) cls_q <= 3'd3;
					else cls_q <= 3'd4;
					hid_q <= (mx_q > p95_q);
					out_q <= (48'(mx_q) > ratio_prod);
					num_q <= {(p95_q - p5_q), 8'd0};
					rem_q <= '0;
					dcnt_q <= 6'd40;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (rem_sub[32] == 1'b0) begin
						rem_q <= rem_sub;
						num_q <= {num_q[38:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[38:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) state_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) state_q <= ST_LOAD;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign p5_value = p5_q;
	assign p50_value = p50_q;
	assign p95_value = p95_q;
	assign p99_value = p99_q;
	assign max_value = mx_q;
	assign gap_class = cls_q;
	assign hidden_outlier = hid_q;
	assign outlier_flag = out_q;
	assign timeout_value = 33'(p99_q) + 33'(p99_q >> 1);
	assign spread_ratio = (p50_q == 32'd0 || num_q[39:24] != 16'd0) ? SPREAD_SAT
		: num_q[23:0];

	property p_result_holds;
		@(posedge clk) disable iff (!arst_n) out_valid && out_stall |=> out_valid;
	endproperty
	a_result_holds: assert property (p_result_holds) else $error("result dropped");

	property p_no_take_busy;
		@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall;
	endproperty
	a_no_take_busy: assert property (p_no_take_busy) else $error("input taken while busy");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) load_count_q < CW'(MAX_SAMPLES)
			&& (state_q == ST_LOAD || load_count_q == '0);
	endproperty
	a_count_range: assert property (p_count_range) else $error("load count overrun");
endmodule
`default_nettype wire

// File: tb/latency_percentile_outlier_monitor_top_tb.sv
module latency_percentile_outlier_monitor_top_tb import lpom_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WIN_MAX = 128;
	localparam int unsigned STALL_LIMIT = 300000;

	typedef struct {
		logic [31:0] p5, p50, p95, p99, mx;
		logic [2:0]  gap;
		logic        hidden, outlier;
		logic [32:0] tmo;
		logic [23:0] spread;
	} window_stats_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid, in_stall;
	logic [31:0] sample;
	logic        out_valid, out_stall;
	logic [31:0] p5_value, p50_value, p95_value, p99_value, max_value;
	logic [2:0]  gap_class;
	logic        hidden_outlier, outlier_flag;
	logic [32:0] timeout_value;
	logic [23:0] spread_ratio;

	latency_percentile_outlier_monitor_top #(.MAX_SAMPLES(WIN_MAX)) u_top (.*);

	// predictor state
	logic [31:0]   win_store [WIN_MAX];
	int unsigned   win_fill;
	logic [7:0]    cfg_count;
	logic [15:0]   cfg_ratio;
	window_stats_t stats_q [$];
	int unsigned   err_cnt;
	int unsigned   snd_idle_pct, rcv_idle_pct;
	int unsigned   idle_cnt;
	bit            hold_req;
	int unsigned   hold_cnt;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic window_stats_t window_stats(input int unsigned n);
		logic [31:0]   srt [WIN_MAX];
		logic [31:0]   t;
		logic [63:0]   sp;
		window_stats_t r;
		for (int i = 0; i < n; i++) srt[i] = win_store[i];
		for (int i = 0; i + 1 < n; i++)
			for (int j = 0; j + 1 < n - i; j++)
				if (srt[j] > srt[j + 1]) begin
					t = srt[j]; srt[j] = srt[j + 1]; srt[j + 1] = t;
				end
		r.p5  = srt[(n * 5) / 100];
		r.p50 = srt[n / 2];
		r.p95 = srt[(n * 95) / 100];
		r.p99 = srt[(n * 99) / 100];
		r.mx  = srt[n - 1];
		// gap class from integer compares
		if (r.p50 == 0) r.gap = 3'd4;
		else if (64'(r.p95) * 100 < 64'(r.p50) * 101) r.gap = 3'd0;
		else if (64'(r.p95) * 100 < 64'(r.p50) * 130) r.gap = 3'd1;
		else if (64'(r.p95) < 64'(r.p50) * 3) r.gap = 3'd2;
		else if (64'(r.p95) < 64'(r.p50) * 5) r.gap = 3'd3;
		else r.gap = 3'd4;
		r.hidden  = r.mx > r.p95;
		r.outlier = 64'(r.mx) > 64'(r.p95) * 64'(cfg_ratio);
		r.tmo     = 33'(r.p99) + 33'(r.p99 >> 1);
		if (r.p50 == 0) r.spread = SPREAD_SAT;
		else begin
			sp = (64'(r.p95 - r.p5) << 8) / 64'(r.p50);
			r.spread = (sp > 64'(SPREAD_SAT)) ? SPREAD_SAT : sp[23:0];
		end
		return r;
	endfunction

	function automatic void load_sample(input logic [31:0] s);
		int unsigned n, pos;
		n = (cfg_count < 2) ? 2 : ((cfg_count > WIN_MAX) ? WIN_MAX : cfg_count);
		pos = (win_fill < n) ? win_fill : n - 1;
		win_store[pos] = s;
		win_fill = pos + 1;
		if (win_fill >= n) begin
			stats_q.push_back(window_stats(n));
			win_fill = 0;
		end
	endfunction

	// one sample transfer; stall is sampled between edges, valid stays high afterwards
	task automatic send(input logic [31:0] s);
		bit stalled;
		if ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		do begin
			#1;
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		load_sample(s);
	endtask

	// drop valid and wait for the block to drain
	task automatic settle();
		in_valid <= 1'b0;
		wait (stats_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == ADDR_SAMPLE_COUNT) cfg_count = val[7:0];
		else cfg_ratio = val[15:0];
	endtask

	task automatic set_cfg(input logic [7:0] cnt, input logic [15:0] ratio);
		reg_write(ADDR_SAMPLE_COUNT, 32'(cnt));
		reg_write(ADDR_OUTLIER_RATIO, 32'(ratio));
	endtask

	function automatic logic [31:0] rand_latency();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 3);
			2: return $urandom_range(90, 600);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 2);
		endcase
	endfunction

	function automatic logic [15:0] rand_ratio();
		case ($urandom_range(4))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(1, 3));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
			err_cnt++;
		end
	endtask

	// result checker: sampled mid-cycle, the transfer completes at the next rising edge
	always @(negedge clk) begin
		window_stats_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (stats_q.size() == 0) begin
				$display("%0t: unexpected result transfer, p50 %0h", $time, p50_value);
				err_cnt++;
			end else begin
				e = stats_q.pop_front();
				check_field("p5_value", 64'(e.p5), 64'(p5_value));
				check_field("p50_value", 64'(e.p50), 64'(p50_value));
				check_field("p95_value", 64'(e.p95), 64'(p95_value));
				check_field("p99_value", 64'(e.p99), 64'(p99_value));
				check_field("max_value", 64'(e.mx), 64'(max_value));
				check_field("gap_class", 64'(e.gap), 64'(gap_class));
				check_field("hidden_outlier", 64'(e.hidden), 64'(hidden_outlier));
				check_field("outlier_flag", 64'(e.outlier), 64'(outlier_flag));
				check_field("timeout_value", 64'(e.tmo), 64'(timeout_value));
				check_field("spread_ratio", 64'(e.spread), 64'(spread_ratio));
			end
		end
	end

	// receiver stall generator with a one-shot long hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_cnt = 400;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
		else idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// reset configuration window of 100 samples
	task automatic test_reset_window();
		for (int i = 0; i < 100; i++) send(rand_latency());
		settle();
	endtask

	// field extremes, clamped window lengths, zero median, zero and max ratio
	task automatic test_extremes();
		set_cfg(8'd0, 16'd0);
		send(32'd0); send(32'd0);
		send(32'd0); send(32'hFFFF_FFFF);
		settle();
		set_cfg(8'd1, 16'hFFFF);
		send(32'hFFFF_FFFF); send(32'hFFFF_FFFF);
		send(32'd7); send(32'd3);
		settle();
		set_cfg(8'd5, 16'd1);
		send(32'd1000); send(32'd1); send(32'd2); send(32'd4); send(32'd3);
		settle();
	endtask

	// window length lowered while a window is partly loaded
	task automatic test_shrink();
		set_cfg(8'd8, 16'd2);
		for (int i = 0; i < 5; i++) send(32'(10 * (i + 1)));
		settle();
		reg_write(ADDR_SAMPLE_COUNT, 32'd3);
		send(32'd5);
		settle();
		reg_write(ADDR_SAMPLE_COUNT, 32'd4);
		for (int i = 0; i < 4; i++) send(32'(i + 2));
		settle();
	endtask

	// p95/p50 class boundaries with a window of four
	task automatic test_gap_classes();
		logic [31:0] top_v [8] = '{100, 101, 129, 130, 299, 300, 499, 500};
		set_cfg(8'd4, 16'd3);
		foreach (top_v[k]) begin
			send(32'd1); send(32'd100); send(32'd100); send(top_v[k]);
		end
		settle();
	endtask

	// a full-size window, set with a count above the maximum
	task automatic test_large_window();
		set_cfg(8'd255, rand_ratio());
		for (int i = 0; i < WIN_MAX; i++) send(rand_latency());
		settle();
	endtask

	// random windows of mostly short length
	task automatic test_random(input int unsigned items);
		int unsigned sent;
		sent = 0;
		while (sent < items) begin
			set_cfg(8'($urandom_range(2, 12)), rand_ratio());
			repeat ($urandom_range(3, 8) * cfg_count + $urandom_range(0, 2)) begin
				send(rand_latency());
				sent++;
			end
			settle();
		end
	endtask

	// long receiver hold-off with the sender still offering, then a drain pause
	task automatic test_backpressure();
		set_cfg(8'd2, 16'd2);
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++) send(rand_latency());
		in_valid <= 1'b0;
		wait (stats_q.size() == 0);
		@(posedge clk);
		for (int i = 0; i < 10; i++) send(rand_latency());
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		paddr = '0; pwdata = '0;
		in_valid = 1'b0; sample = '0; out_stall = 1'b0;
		win_fill = 0; cfg_count = 8'd100; cfg_ratio = 16'd2;
		err_cnt = 0; idle_cnt = 0; hold_req = 1'b0; hold_cnt = 0;
		snd_idle_pct = 29; rcv_idle_pct = 52;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_extremes();
		test_shrink();
		test_gap_classes();
		test_large_window();
		test_random(100);
		snd_idle_pct = 52; rcv_idle_pct = 29;
		test_random(100);
		test_backpressure();
		snd_idle_pct = 0; rcv_idle_pct = 0;
		test_random(100);

		settle();
		repeat (50) @(posedge clk);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// File: sim.f
design/lpom_pkg.sv
design/latency_percentile_outlier_monitor_top.sv
tb/latency_percentile_outlier_monitor_top_tb.sv
